@@ rtl/ievq_pkg.sv @@
// Package for the input-event queue: command codes, device codes and the
// item, report and control types shared by the controller and datapath.
// No dependencies.
package ievq_pkg;

  localparam logic [2:0] CMD_REGISTER   = 3'd0;
  localparam logic [2:0] CMD_UNREGISTER = 3'd1;
  localparam logic [2:0] CMD_SUBMIT     = 3'd2;
  localparam logic [2:0] CMD_KEYBOARD   = 3'd3;
  localparam logic [2:0] CMD_MOUSE      = 3'd4;
  localparam logic [2:0] CMD_POP        = 3'd5;

  localparam logic [15:0] TYPE_KEYBOARD = 16'd1;
  localparam logic [15:0] TYPE_MOUSE    = 16'd2;

  localparam int unsigned SLOT_KEYBOARD = 0;
  localparam int unsigned SLOT_MOUSE    = 1;

  typedef struct packed {
    logic [2:0]         cmd;
    logic [4:0]         target_id;
    logic [31:0]        rep_timestamp;
    logic [15:0]        rep_type;
    logic [7:0]         scancode;
    logic [7:0]         keycode;
    logic               pressed;
    logic signed [15:0] x_delta;
    logic signed [15:0] y_delta;
    logic [7:0]         buttons;
  } in_item_t;

  typedef struct packed {
    logic               status;
    logic [3:0]         slot;
    logic               got_report;
    logic [31:0]        out_timestamp;
    logic [15:0]        out_type;
    logic [7:0]         out_scancode;
    logic [7:0]         out_keycode;
    logic               out_pressed;
    logic signed [15:0] out_x;
    logic signed [15:0] out_y;
    logic [7:0]         out_buttons;
    logic [4:0]         device_count;
  } out_item_t;

  // One ring entry.
  typedef struct packed {
    logic [31:0]        stamp;
    logic [15:0]        kind;
    logic [7:0]         scan;
    logic [7:0]         key;
    logic               down;
    logic signed [15:0] dx;
    logic signed [15:0] dy;
    logic [7:0]         btn;
  } report_t;

  // Controller to datapath commands.
  typedef struct packed {
    logic latch;  // capture the accepted input item
    logic exec;   // run the command on slot, counter and ring state
    logic load;   // fill the output register
  } ctrl_cmd_t;

endpackage

@@ rtl/ievq_ctrl.sv @@
// Controller for the input-event queue: sequences capture, execute and
// output load, and owns both handshakes. Depends on ievq_pkg.
module ievq_ctrl
  import ievq_pkg::*;
(
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      in_valid_i,
  output logic      in_ready_o,
  output logic      out_valid_o,
  input  logic      out_ready_i,
  output ctrl_cmd_t ctrl_o
);

  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_EXEC = 2'd1;
  localparam logic [1:0] S_LOAD = 2'd2;

  logic [1:0] state_q, state_d;
  logic       out_valid_q, out_valid_d;
  logic       can_load;
  logic       in_xfer;

  assign can_load   = !out_valid_q || out_ready_i;
  assign in_ready_o = (state_q == S_IDLE) || ((state_q == S_LOAD) && can_load);
  assign in_xfer    = in_valid_i && in_ready_o;

  assign ctrl_o.latch = in_xfer;
  assign ctrl_o.exec  = (state_q == S_EXEC);
  assign ctrl_o.load  = (state_q == S_LOAD) && can_load;

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      S_IDLE: begin
        if (in_xfer) state_d = S_EXEC;
      end
      S_EXEC: begin
        state_d = S_LOAD;
      end
      S_LOAD: begin
        if (can_load) state_d = in_xfer ? S_EXEC : S_IDLE;
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_comb begin
    out_valid_d = out_valid_q;
    if (out_valid_q && out_ready_i) out_valid_d = 1'b0;
    if (ctrl_o.load) out_valid_d = 1'b1;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  assign out_valid_o = out_valid_q;

endmodule

@@ rtl/ievq_dp.sv @@
// Datapath for the input-event queue: slot pool, device count, stamp
// counter, report ring with cursors, and the output register. Depends on ievq_pkg.
module ievq_dp
  import ievq_pkg::*;
#(
  parameter int unsigned DEVICE_SLOTS = 16,
  parameter int unsigned QUEUE_DEPTH  = 256
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  ctrl_cmd_t ctrl_i,
  input  in_item_t  in_item_i,
  output out_item_t out_item_o
);

  localparam int unsigned SW = $clog2(DEVICE_SLOTS);
  localparam int unsigned CW = $clog2(DEVICE_SLOTS + 1);
  localparam int unsigned AW = $clog2(QUEUE_DEPTH);
  localparam int unsigned FW = $clog2(QUEUE_DEPTH + 1);

  in_item_t                item_q;
  logic [DEVICE_SLOTS-1:0] conn_q, conn_d;
  logic [CW-1:0]           dev_cnt_q, dev_cnt_d;
  logic [31:0]             stamp_q, stamp_d;
  logic [AW-1:0]           rd_ptr_q, rd_ptr_d;
  logic [AW-1:0]           wr_ptr_q, wr_ptr_d;
  logic [FW-1:0]           fill_q, fill_d;
  logic                    res_status_q, res_status_d;
  logic [3:0]              res_slot_q, res_slot_d;
  logic                    res_got_q, res_got_d;

  report_t                 ring_mem [QUEUE_DEPTH];
  report_t                 rdata_q;
  out_item_t               out_q;

  logic [SW-1:0] id_idx;
  logic          id_ok;
  logic          free_found;
  logic [SW-1:0] free_idx;
  logic          push;
  logic          pop;
  report_t       entry;
  logic [AW-1:0] wr_next, rd_next;

  assign id_idx = SW'(item_q.target_id);
  assign id_ok  = (32'(item_q.target_id) < 32'(DEVICE_SLOTS)) && conn_q[id_idx];

  // Lowest free slot.
  always_comb begin
    free_found = 1'b0;
    free_idx   = '0;
    for (int i = DEVICE_SLOTS - 1; i >= 0; i--) begin
      if (!conn_q[i]) begin
        free_found = 1'b1;
        free_idx   = SW'(i);
      end
    end
  end

  assign wr_next = (wr_ptr_q == AW'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
  assign rd_next = (rd_ptr_q == AW'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;

  always_comb begin
    entry = '0;
    push  = 1'b0;
    case (item_q.cmd)
      CMD_SUBMIT: begin
        entry.stamp = item_q.rep_timestamp;
        entry.kind  = item_q.rep_type;
        entry.scan  = item_q.scancode;
        entry.key   = item_q.keycode;
        entry.down  = item_q.pressed;
        entry.dx    = item_q.x_delta;
        entry.dy    = item_q.y_delta;
        entry.btn   = item_q.buttons;
        push        = id_ok;
      end
      CMD_KEYBOARD: begin
        entry.stamp = stamp_q + 32'd1;
        entry.kind  = TYPE_KEYBOARD;
        entry.scan  = item_q.scancode;
        entry.key   = item_q.keycode;
        entry.down  = item_q.pressed;
        push        = conn_q[SLOT_KEYBOARD];
      end
      CMD_MOUSE: begin
        entry.stamp = stamp_q + 32'd1;
        entry.kind  = TYPE_MOUSE;
        entry.dx    = item_q.x_delta;
        entry.dy    = item_q.y_delta;
        entry.btn   = item_q.buttons;
        push        = conn_q[SLOT_MOUSE];
      end
      default: begin
        push = 1'b0;
      end
    endcase
  end

  assign pop = (item_q.cmd == CMD_POP) && (fill_q != '0);

  always_comb begin
    conn_d       = conn_q;
    dev_cnt_d    = dev_cnt_q;
    stamp_d      = stamp_q;
    rd_ptr_d     = rd_ptr_q;
    wr_ptr_d     = wr_ptr_q;
    fill_d       = fill_q;
    res_status_d = res_status_q;
    res_slot_d   = res_slot_q;
    res_got_d    = res_got_q;
    if (ctrl_i.exec) begin
      res_status_d = 1'b1;
      res_slot_d   = '0;
      res_got_d    = 1'b0;
      if (item_q.cmd == CMD_KEYBOARD || item_q.cmd == CMD_MOUSE) stamp_d = stamp_q + 32'd1;
      case (item_q.cmd)
        CMD_REGISTER: begin
          if (free_found) begin
            conn_d[free_idx] = 1'b1;
            dev_cnt_d        = dev_cnt_q + 1'b1;
            res_status_d     = 1'b0;
            res_slot_d       = 4'(free_idx);
          end
        end
        CMD_UNREGISTER: begin
          if (id_ok) begin
            conn_d[id_idx] = 1'b0;
            if (dev_cnt_q != '0) dev_cnt_d = dev_cnt_q - 1'b1;
            res_status_d = 1'b0;
          end
        end
        CMD_POP: begin
          if (pop) begin
            rd_ptr_d     = rd_next;
            fill_d       = fill_q - 1'b1;
            res_status_d = 1'b0;
            res_got_d    = 1'b1;
            // Ring drained: rewind both cursors.
            if (fill_q == FW'(1)) begin
              rd_ptr_d = '0;
              wr_ptr_d = '0;
            end
          end
        end
        default: begin
          if (push) begin
            res_status_d = 1'b0;
            wr_ptr_d     = wr_next;
            if (fill_q == FW'(QUEUE_DEPTH)) rd_ptr_d = rd_next;  // overwrite oldest
            else fill_d = fill_q + 1'b1;
          end
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      conn_q       <= {{(DEVICE_SLOTS-2){1'b0}}, 2'b11};
      dev_cnt_q    <= CW'(2);
      stamp_q      <= '0;
      rd_ptr_q     <= '0;
      wr_ptr_q     <= '0;
      fill_q       <= '0;
      res_status_q <= 1'b1;
      res_slot_q   <= '0;
      res_got_q    <= 1'b0;
    end else begin
      conn_q       <= conn_d;
      dev_cnt_q    <= dev_cnt_d;
      stamp_q      <= stamp_d;
      rd_ptr_q     <= rd_ptr_d;
      wr_ptr_q     <= wr_ptr_d;
      fill_q       <= fill_d;
      res_status_q <= res_status_d;
      res_slot_q   <= res_slot_d;
      res_got_q    <= res_got_d;
    end
  end

  // Ring memory: one write port, one registered read port.
  always_ff @(posedge clk_i) begin
    if (ctrl_i.exec && push) ring_mem[wr_ptr_q] <= entry;
    if (ctrl_i.exec && pop)  rdata_q <= ring_mem[rd_ptr_q];
  end

  always_ff @(posedge clk_i) begin
    if (ctrl_i.latch) item_q <= in_item_i;
    if (ctrl_i.load) begin
      out_q.status       <= res_status_q;
      out_q.slot         <= res_slot_q;
      out_q.got_report   <= res_got_q;
      out_q.device_count <= 5'(dev_cnt_q);
      if (res_got_q) begin
        out_q.out_timestamp <= rdata_q.stamp;
        out_q.out_type      <= rdata_q.kind;
        out_q.out_scancode  <= rdata_q.scan;
        out_q.out_keycode   <= rdata_q.key;
        out_q.out_pressed   <= rdata_q.down;
        out_q.out_x         <= rdata_q.dx;
        out_q.out_y         <= rdata_q.dy;
        out_q.out_buttons   <= rdata_q.btn;
      end else begin
        out_q.out_timestamp <= '0;
        out_q.out_type      <= '0;
        out_q.out_scancode  <= '0;
        out_q.out_keycode   <= '0;
        out_q.out_pressed   <= 1'b0;
        out_q.out_x         <= '0;
        out_q.out_y         <= '0;
        out_q.out_buttons   <= '0;
      end
    end
  end

  assign out_item_o = out_q;

endmodule

@@ rtl/input_event_queue_with_slots.sv @@
// Top level of the input-event queue with device slots.
// Instantiates ievq_ctrl and ievq_dp; depends on ievq_pkg.
//
// Usage:
//   One command per input transfer on in_valid_i/in_ready_o, payload
//   in_item_i (register, unregister, submit, keyboard, mouse, pop).
//   Every command gives exactly one result transfer on
//   out_valid_o/out_ready_i, payload out_item_o, in command order.
// Sequence: after the input transfer the command executes against slot
//   state and the ring, then the output register is loaded; a pop's ring
//   read is registered in the execute step.
// Overlap: the next command is taken in the load step of the last one while
//   the output register is free, as set by the controller's execute/load
//   sequence around the ring's registered read port. Stall: while out_valid_o
//   waits on out_ready_i, one more command is taken and executed; it then holds
//   in the load step, and in_ready_o stays low, until the output register frees.
// Reset: slots 0 and 1 connected, device count 2, ring empty, cursors and
//   stamp counter zero. Ring storage is not cleared; pops only read
//   entries that were written.
module input_event_queue_with_slots
  import ievq_pkg::*;
#(
  parameter int unsigned DEVICE_SLOTS = 16,
  parameter int unsigned QUEUE_DEPTH  = 256
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      in_valid_i,
  output logic      in_ready_o,
  input  in_item_t  in_item_i,
  output logic      out_valid_o,
  input  logic      out_ready_i,
  output out_item_t out_item_o
);

  ctrl_cmd_t ctrl;

  // Sequencer and both handshakes.
  ievq_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .out_valid_o(out_valid_o),
    .out_ready_i(out_ready_i),
    .ctrl_o     (ctrl)
  );

  // Slot pool, stamp counter, report ring and output register.
  ievq_dp #(
    .DEVICE_SLOTS(DEVICE_SLOTS),
    .QUEUE_DEPTH (QUEUE_DEPTH)
  ) u_dp (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .ctrl_i    (ctrl),
    .in_item_i (in_item_i),
    .out_item_o(out_item_o)
  );

endmodule

@@ rtl/ievq_checker.sv @@
// Port-level checks for the input-event queue, bound to the top level.
// Depends on ievq_pkg.
module ievq_checker
  import ievq_pkg::*;
#(
  parameter int unsigned DEVICE_SLOTS = 16
) (
  input logic      clk_i,
  input logic      rst_ni,
  input logic      in_valid_i,
  input logic      in_ready_o,
  input logic      out_valid_o,
  input logic      out_ready_i,
  input out_item_t out_item_o
);

  // A result waiting on the receiver holds.
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(out_item_o))
    else $error("result changed while stalled");

  // One command at a time: no transfer right after a transfer.
  a_seq: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_o |=> !in_ready_o)
    else $error("input taken during execute");

  // A returned report is a success.
  a_got_ok: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_item_o.got_report |-> !out_item_o.status)
    else $error("report with failure status");

  // Failure carries no slot and an all-zero report.
  a_fail_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_item_o.status |->
      out_item_o.slot == '0 && out_item_o.out_timestamp == '0 &&
      out_item_o.out_type == '0 && out_item_o.out_buttons == '0)
    else $error("failure result carries data");

  // Device count never exceeds the pool.
  a_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> 32'(out_item_o.device_count) <= 32'(DEVICE_SLOTS))
    else $error("device count out of range");

endmodule

bind input_event_queue_with_slots ievq_checker #(.DEVICE_SLOTS(DEVICE_SLOTS)) u_ievq_checker (.*);

@@ bench/testbench.sv @@
// Self-checking bench for input_event_queue_with_slots: random and directed commands
// through the valid/ready channels, with an in-bench predictor of the slots and the ring.
// Depends on ievq_pkg and the RTL of the block.
module testbench;
  timeunit 1ns;
  timeprecision 1ps;
  import ievq_pkg::*;

  localparam int unsigned SLOTS        = 16;
  localparam int unsigned RING_SLOTS   = 256;
  localparam int unsigned ITEM_TARGET  = 1700;
  localparam int unsigned TAIL_ITEMS   = 150;     // no idling while this few remain
  localparam int unsigned SETTLE_LIMIT = 8;       // quiet cycles after the last result
  localparam int unsigned CYCLE_LIMIT  = 600000;  // watchdog

  // Command codes the package leaves unnamed; the block answers them with a failure.
  localparam logic [2:0] CMD_SPARE_A = 3'd6;
  localparam logic [2:0] CMD_SPARE_B = 3'd7;

  logic      clk_i       = 1'b0;
  logic      rst_ni      = 1'b0;
  logic      in_valid_i  = 1'b0;
  logic      in_ready_o;
  in_item_t  in_item_i   = '0;
  logic      out_valid_o;
  logic      out_ready_i = 1'b0;
  out_item_t out_item_o;

  input_event_queue_with_slots dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .in_item_i  (in_item_i),
    .out_valid_o(out_valid_o),
    .out_ready_i(out_ready_i),
    .out_item_o (out_item_o)
  );

  always #5 clk_i = ~clk_i;

  // Reset is asserted from the start and then released for good.
  initial begin
    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;
  end

  // ---------------------------------------------------------------------------
  // Predictor state: slot pool, event ring and stamp counter, as the block
  // should hold them after each accepted transfer.
  // ---------------------------------------------------------------------------
  logic        slot_live [SLOTS];
  logic [4:0]  live_count;
  report_t     ring_mem [RING_SLOTS];
  logic [7:0]  head_ptr;     // oldest report
  logic [7:0]  tail_ptr;     // next free entry; 8 bits wrap at the ring depth
  logic [8:0]  ring_fill;
  logic [31:0] stamp_count;

  in_item_t  pending_cmds[$];       // stimulus not yet offered
  out_item_t expected_results[$];   // one per accepted command, in order

  int unsigned planned;
  int unsigned taken;
  int unsigned checked;
  int unsigned mismatches;
  int unsigned overwrites;
  int unsigned refused_events;
  int unsigned pool_full_hits;
  int unsigned reports_popped;
  int unsigned send_gap;
  int unsigned hold_gap;
  int unsigned cycles;

  initial begin
    for (int i = 0; i < SLOTS; i++) slot_live[i] = (i == SLOT_KEYBOARD) || (i == SLOT_MOUSE);
    live_count  = 5'd2;
    head_ptr    = '0;
    tail_ptr    = '0;
    ring_fill   = '0;
    stamp_count = '0;
  end

  // Push a report to a slot; returns the status bit (1 = slot bad or closed).
  function automatic logic file_report(int unsigned id, report_t rep);
    if (id >= SLOTS || !slot_live[id]) return 1'b1;
    ring_mem[tail_ptr] = rep;
    tail_ptr++;
    if (ring_fill < RING_SLOTS) begin
      ring_fill++;
    end else begin
      // full ring: the oldest report is lost
      head_ptr++;
      overwrites++;
    end
    return 1'b0;
  endfunction

  function automatic out_item_t apply_command(in_item_t it);
    out_item_t   res;
    report_t     rep;
    int unsigned free_slot;
    logic        found;
    res       = '0;
    rep       = '0;
    found     = 1'b0;
    free_slot = 0;
    res.status = 1'b1;
    case (it.cmd)
      CMD_REGISTER: begin
        for (int s = 0; s < SLOTS; s++) begin
          if (!found && !slot_live[s]) begin
            found     = 1'b1;
            free_slot = s;
          end
        end
        if (found) begin
          slot_live[free_slot] = 1'b1;
          live_count++;
          res.status = 1'b0;
          res.slot   = 4'(free_slot);
        end else begin
          pool_full_hits++;
        end
      end
      CMD_UNREGISTER: begin
        if (it.target_id < SLOTS && slot_live[it.target_id]) begin
          slot_live[it.target_id] = 1'b0;
          if (live_count > 0) live_count--;
          res.status = 1'b0;
        end
      end
      CMD_SUBMIT: begin
        rep = '{stamp: it.rep_timestamp, kind: it.rep_type, scan: it.scancode,
                key: it.keycode, down: it.pressed, dx: it.x_delta, dy: it.y_delta,
                btn: it.buttons};
        res.status = file_report(it.target_id, rep);
      end
      CMD_KEYBOARD: begin
        stamp_count++;
        rep.stamp  = stamp_count;
        rep.kind   = TYPE_KEYBOARD;
        rep.scan   = it.scancode;
        rep.key    = it.keycode;
        rep.down   = it.pressed;
        res.status = file_report(SLOT_KEYBOARD, rep);
        if (res.status) refused_events++;
      end
      CMD_MOUSE: begin
        stamp_count++;
        rep.stamp  = stamp_count;
        rep.kind   = TYPE_MOUSE;
        rep.dx     = it.x_delta;
        rep.dy     = it.y_delta;
        rep.btn    = it.buttons;
        res.status = file_report(SLOT_MOUSE, rep);
        if (res.status) refused_events++;
      end
      CMD_POP: begin
        if (ring_fill > 0) begin
          rep = ring_mem[head_ptr];
          head_ptr++;
          ring_fill--;
          // a drained ring rewinds both cursors
          if (ring_fill == 0) begin
            head_ptr = '0;
            tail_ptr = '0;
          end
          res.status        = 1'b0;
          res.got_report    = 1'b1;
          res.out_timestamp = rep.stamp;
          res.out_type      = rep.kind;
          res.out_scancode  = rep.scan;
          res.out_keycode   = rep.key;
          res.out_pressed   = rep.down;
          res.out_x         = rep.dx;
          res.out_y         = rep.dy;
          res.out_buttons   = rep.btn;
        end
      end
      default: ;  // spare codes change nothing
    endcase
    res.device_count = live_count;
    return res;
  endfunction

  // ---------------------------------------------------------------------------
  // Result checking
  // ---------------------------------------------------------------------------
  task automatic compare_field(string name, logic [31:0] want, logic [31:0] got);
    if (want !== got) begin
      $display("%0t ns: result %0d field %s mismatch, expected %0h, actual %0h",
               $time, checked, name, want, got);
      mismatches++;
    end
  endtask

  task automatic check_result(out_item_t got);
    out_item_t want;
    if (expected_results.size() == 0) begin
      $display("%0t ns: unexpected result transfer, expected none, actual %0h", $time, got);
      mismatches++;
    end else begin
      want = expected_results.pop_front();
      compare_field("status", want.status, got.status);
      compare_field("slot", want.slot, got.slot);
      compare_field("got_report", want.got_report, got.got_report);
      compare_field("out_timestamp", want.out_timestamp, got.out_timestamp);
      compare_field("out_type", want.out_type, got.out_type);
      compare_field("out_scancode", want.out_scancode, got.out_scancode);
      compare_field("out_keycode", want.out_keycode, got.out_keycode);
      compare_field("out_pressed", want.out_pressed, got.out_pressed);
      compare_field("out_x", want.out_x, got.out_x);
      compare_field("out_y", want.out_y, got.out_y);
      compare_field("out_buttons", want.out_buttons, got.out_buttons);
      compare_field("device_count", want.device_count, got.device_count);
      if (want.got_report) reports_popped++;
    end
    checked++;
  endtask

  // ---------------------------------------------------------------------------
  // Driver: offers queued commands, with random idle bursts until the tail of
  // the run. The prediction runs on each accepted transfer.
  // ---------------------------------------------------------------------------
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (in_valid_i && in_ready_o) begin
        expected_results.push_back(apply_command(in_item_i));
        taken++;
      end
      // valid stays up with the same payload until the transfer happens
      if (!in_valid_i || in_ready_o) begin
        if (send_gap > 0) begin
          send_gap--;
          in_valid_i <= 1'b0;
        end else if (pending_cmds.size() > TAIL_ITEMS && $urandom_range(0, 9) == 0) begin
          send_gap = $urandom_range(0, 18);
          in_valid_i <= 1'b0;
        end else if (pending_cmds.size() > 0) begin
          in_item_i  <= pending_cmds.pop_front();
          in_valid_i <= 1'b1;
        end else begin
          in_valid_i <= 1'b0;
        end
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Monitor: takes result transfers and stalls the output in random bursts.
  // ---------------------------------------------------------------------------
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (out_valid_o && out_ready_i) check_result(out_item_o);
      if (hold_gap > 0) begin
        hold_gap--;
        out_ready_i <= 1'b0;
      end else if (pending_cmds.size() > TAIL_ITEMS && $urandom_range(0, 9) == 0) begin
        hold_gap = $urandom_range(0, 18);
        out_ready_i <= 1'b0;
      end else begin
        out_ready_i <= 1'b1;
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Stimulus
  // ---------------------------------------------------------------------------
  function automatic in_item_t new_item(logic [2:0] op, logic [4:0] id);
    in_item_t it;
    it.cmd           = op;
    it.target_id     = id;
    it.rep_timestamp = $urandom;
    it.rep_type      = ($urandom_range(0, 3) == 0) ? 16'($urandom)
                     : ($urandom_range(0, 1) ? TYPE_KEYBOARD : TYPE_MOUSE);
    it.scancode      = 8'($urandom);
    it.keycode       = 8'($urandom);
    it.pressed       = 1'($urandom);
    it.x_delta       = 16'($urandom);
    it.y_delta       = 16'($urandom);
    it.buttons       = 8'($urandom);
    return it;
  endfunction

  // Mostly valid slots, sometimes ids past the pool.
  function automatic logic [4:0] pick_id();
    return ($urandom_range(0, 9) == 0) ? 5'($urandom_range(SLOTS, 31))
                                       : 5'($urandom_range(0, SLOTS - 1));
  endfunction

  function automatic in_item_t mixed_item();
    int unsigned roll;
    roll = $urandom_range(0, 99);
    if (roll < 12) return new_item(CMD_REGISTER, pick_id());
    if (roll < 24) return new_item(CMD_UNREGISTER, pick_id());
    if (roll < 42) return new_item(CMD_SUBMIT, pick_id());
    if (roll < 60) return new_item(CMD_KEYBOARD, pick_id());
    if (roll < 78) return new_item(CMD_MOUSE, pick_id());
    if (roll < 97) return new_item(CMD_POP, pick_id());
    return new_item($urandom_range(0, 1) ? CMD_SPARE_A : CMD_SPARE_B, pick_id());
  endfunction

  task automatic plan_item(in_item_t it);
    pending_cmds.push_back(it);
    // spare codes change no state in the block and do not count toward the plan
    if (it.cmd != CMD_SPARE_A && it.cmd != CMD_SPARE_B) planned++;
  endtask

  initial begin
    in_item_t    it;
    int unsigned roll;
    int unsigned len;

    // Directed opening: empty pop, spare code, bad id, filling the pool to
    // overflow, extreme field values, a refused event and draining the ring.
    plan_item(new_item(CMD_POP, 5'd0));
    plan_item(new_item(CMD_SPARE_B, 5'd31));
    plan_item(new_item(CMD_UNREGISTER, 5'd31));
    repeat (SLOTS - 2) plan_item(new_item(CMD_REGISTER, 5'd0));
    plan_item(new_item(CMD_REGISTER, 5'd0));
    it = new_item(CMD_SUBMIT, 5'd15);
    it.rep_timestamp = '1;
    it.rep_type      = '1;
    it.scancode      = '1;
    it.keycode       = '1;
    it.pressed       = 1'b1;
    it.x_delta       = 16'sh7fff;
    it.y_delta       = 16'sh8000;
    it.buttons       = '1;
    plan_item(it);
    it = new_item(CMD_SUBMIT, 5'd1);
    it.rep_timestamp = '0;
    it.rep_type      = '0;
    it.scancode      = '0;
    it.keycode       = '0;
    it.pressed       = 1'b0;
    it.x_delta       = '0;
    it.y_delta       = '0;
    it.buttons       = '0;
    plan_item(it);
    it = new_item(CMD_KEYBOARD, 5'd0);
    it.scancode = '1;
    it.keycode  = '0;
    it.pressed  = 1'b1;
    plan_item(it);
    it = new_item(CMD_MOUSE, 5'd0);
    it.x_delta = 16'sh8000;
    it.y_delta = 16'sh7fff;
    it.buttons = '0;
    plan_item(it);
    plan_item(new_item(CMD_UNREGISTER, 5'd0));
    plan_item(new_item(CMD_KEYBOARD, 5'd0));   // slot 0 closed: refused, stamp still moves
    repeat (4) plan_item(new_item(CMD_POP, 5'd0));

    // Random segments: mixed traffic, floods of events that overrun the ring,
    // and drains that empty it and pop past the end.
    while (planned < ITEM_TARGET) begin
      roll = $urandom_range(0, 3);
      if (roll < 2) begin
        len = $urandom_range(50, 150);
        repeat (len) plan_item(mixed_item());
      end else if (roll == 2) begin
        // make sure the fixed slots are open before the flood
        repeat (2) plan_item(new_item(CMD_REGISTER, pick_id()));
        len = $urandom_range(260, 330);
        repeat (len) begin
          roll = $urandom_range(0, 99);
          if (roll < 45)      plan_item(new_item(CMD_KEYBOARD, pick_id()));
          else if (roll < 90) plan_item(new_item(CMD_MOUSE, pick_id()));
          else if (roll < 98) plan_item(new_item(CMD_SUBMIT, 5'($urandom_range(0, 1))));
          else                plan_item(new_item(CMD_POP, pick_id()));
        end
      end else begin
        len = $urandom_range(40, 300);
        repeat (len) begin
          if ($urandom_range(0, 99) < 88) plan_item(new_item(CMD_POP, pick_id()));
          else                            plan_item(mixed_item());
        end
      end
    end

    // Wait for every command to go in and every result to come back.
    while (pending_cmds.size() > 0 || in_valid_i || expected_results.size() > 0)
      @(posedge clk_i);
    repeat (SETTLE_LIMIT) @(posedge clk_i);

    if (expected_results.size() > 0) begin
      $display("%0t ns: %0d results never arrived, expected %0h, actual none",
               $time, expected_results.size(), expected_results[0]);
      mismatches++;
    end

    $display("Covered %0d commands and %0d results; %0d reports popped, %0d overwritten.",
             taken, checked, reports_popped, overwrites);
    $display("Pool-full registers: %0d, refused events: %0d, field mismatches: %0d.",
             pool_full_hits, refused_events, mismatches);
    if (mismatches == 0) begin
      $display("testbench passed");
    end else begin
      $display("testbench failed");
    end
    $finish;
  end

  // Watchdog: a hung handshake ends the run here.
  initial begin
    while (cycles < CYCLE_LIMIT) begin
      @(posedge clk_i);
      cycles++;
    end
    $display("Timeout after %0d cycles with %0d results outstanding.",
             cycles, expected_results.size());
    $display("testbench failed");
    $finish;
  end

endmodule
